// ===== sv/page_extent_first_fit_allocator_assert.svh =====
// Assertion macros for the page extent allocator.
// No dependencies; taken in by the files that assert.
`ifndef PAGE_EXTENT_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define PAGE_EXTENT_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PEF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pef assertion failed");
`define PEF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pef implication failed");
`else
`define PEF_ASSERT(label, clk, rst_n, prop)
`define PEF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pef_pkg.sv =====
// Shared types and constants of the page extent allocator.
// No dependencies.
package pef_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned PAGE_W   = 20;
  localparam int unsigned LPAGE_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KB_W     = 22;
  localparam int unsigned KB_SHIFT = KB_W - PAGE_W;

  localparam logic [PAGE_W-1:0]  HIGH_SIZE_MAX = '1;
  localparam logic [LPAGE_W-1:0] LOW_SIZE_MAX  = '1;
  localparam logic [KB_W-1:0]    KB_MAX        = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC_HIGH = 2'd0,
    FN_ALLOC_LOW  = 2'd1,
    FN_ADD_HIGH   = 2'd2,
    FN_ADD_LOW    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              add;
    logic              sub;
    logic [PAGE_W-1:0] amount;
  } free_upd_t;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] start_page;
  } result_t;

endpackage

// ===== sv/pef_if.sv =====
// Request and response channel interfaces of the page extent allocator.
// Depends on pef_pkg.
interface pef_in_if;
  import pef_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [COUNT_W-1:0]  page_count;
  logic [PAGE_W-1:0]   page_number;
  modport source (output valid, output func, output page_count, output page_number,
                  input ready);
  modport sink (input valid, input func, input page_count, input page_number,
                output ready);
endinterface

interface pef_out_if;
  import pef_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   start_page;
  logic [KB_W-1:0]     free_kb;
  modport source (output valid, output status, output start_page, output free_kb,
                  input ready);
  modport sink (input valid, input status, input start_page, input free_kb,
                output ready);
endinterface

// ===== sv/pef_engine.sv =====
// Extent tables and the first-fit search sequencer.
// Depends on pef_pkg; holds both pool memories.
module pef_engine #(
  parameter int unsigned TABLE_ENTRIES = pef_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES),
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  pef_pkg::func_e                    func_i,
  input  logic [pef_pkg::COUNT_W-1:0]       count_i,
  input  logic [pef_pkg::PAGE_W-1:0]        page_i,
  output logic                              ready_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output pef_pkg::result_t                  res_o,
  output pef_pkg::free_upd_t                upd_o,
  output logic [CW-1:0]                     high_used_o,
  output logic [CW-1:0]                     low_used_o
);
  import pef_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       high_used_q, high_used_d;
  logic [CW-1:0]       low_used_q, low_used_d;
  logic                pool_q, pool_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [AW-1:0]       addr_q, addr_d;
  result_t             res_q, res_d;

  logic [2*PAGE_W-1:0]  hi_mem [TABLE_ENTRIES];
  logic [2*LPAGE_W-1:0] lo_mem [TABLE_ENTRIES];
  logic [2*PAGE_W-1:0]  hi_rdata_q;
  logic [2*LPAGE_W-1:0] lo_rdata_q;

  logic                 rd_en, hi_we, lo_we;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [2*PAGE_W-1:0]  hi_wdata;
  logic [2*LPAGE_W-1:0] lo_wdata;

  logic [PAGE_W-1:0]    sel_start, sel_size, hi_new_start, new_size;
  logic [LPAGE_W-1:0]   lo_new_start, lo_sat;
  logic [PAGE_W-1:0]    hi_sat;
  logic [CW-1:0]        used_sel, used_in;
  logic                 fit, last;

  always_ff @(posedge clk_i) begin
    if (hi_we) hi_mem[wr_addr] <= hi_wdata;
    if (rd_en) hi_rdata_q <= hi_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[wr_addr] <= lo_wdata;
    if (rd_en) lo_rdata_q <= lo_mem[rd_addr];
  end

  always_comb begin
    if (pool_q) begin
      sel_start = PAGE_W'(lo_rdata_q[2*LPAGE_W-1:LPAGE_W]);
      sel_size  = PAGE_W'(lo_rdata_q[LPAGE_W-1:0]);
      used_sel  = low_used_q;
    end else begin
      sel_start = hi_rdata_q[2*PAGE_W-1:PAGE_W];
      sel_size  = hi_rdata_q[PAGE_W-1:0];
      used_sel  = high_used_q;
    end
    fit          = {1'b0, sel_size} >= count_q;
    new_size     = sel_size - count_q[PAGE_W-1:0];
    hi_new_start = sel_start + count_q[PAGE_W-1:0];
    lo_new_start = sel_start[LPAGE_W-1:0] + count_q[LPAGE_W-1:0];
    last         = (CW'(addr_q) + CW'(1)) == used_sel;
    hi_sat       = (count_i > COUNT_W'(HIGH_SIZE_MAX)) ? HIGH_SIZE_MAX
                                                       : count_i[PAGE_W-1:0];
    lo_sat       = (count_i > COUNT_W'(LOW_SIZE_MAX)) ? LOW_SIZE_MAX
                                                      : count_i[LPAGE_W-1:0];
    used_in      = (func_i == FN_ALLOC_LOW) ? low_used_q : high_used_q;
  end

  always_comb begin
    state_d     = state_q;
    high_used_d = high_used_q;
    low_used_d  = low_used_q;
    pool_d      = pool_q;
    count_d     = count_q;
    addr_d      = addr_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    hi_we       = 1'b0;
    lo_we       = 1'b0;
    wr_addr     = addr_q;
    hi_wdata    = {hi_new_start, new_size};
    lo_wdata    = {lo_new_start, new_size[LPAGE_W-1:0]};
    upd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          count_d = count_i;
          pool_d  = (func_i == FN_ALLOC_LOW) || (func_i == FN_ADD_LOW);
          res_d   = '{status: ST_OK, start_page: '0};
          state_d = S_DONE;
          case (func_i)
            FN_ALLOC_HIGH, FN_ALLOC_LOW: begin
              if (used_in == '0) begin
                res_d.status = ST_NOFIT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                addr_d  = '0;
                state_d = S_SCAN;
              end
            end
            FN_ADD_HIGH: begin
              if (high_used_q == CW'(TABLE_ENTRIES)) begin
                res_d.status = ST_FULL;
              end else begin
                hi_we        = 1'b1;
                wr_addr      = high_used_q[AW-1:0];
                hi_wdata     = {page_i, hi_sat};
                high_used_d  = high_used_q + CW'(1);
                upd_o.add    = 1'b1;
                upd_o.amount = hi_sat;
              end
            end
            FN_ADD_LOW: begin
              if (low_used_q == CW'(TABLE_ENTRIES)) begin
                res_d.status = ST_FULL;
              end else begin
                lo_we        = 1'b1;
                wr_addr      = low_used_q[AW-1:0];
                lo_wdata     = {page_i[LPAGE_W-1:0], lo_sat};
                low_used_d   = low_used_q + CW'(1);
                upd_o.add    = 1'b1;
                upd_o.amount = PAGE_W'(lo_sat);
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (fit) begin
          hi_we        = !pool_q;
          lo_we        = pool_q;
          upd_o.sub    = 1'b1;
          upd_o.amount = count_q[PAGE_W-1:0];
          res_d        = '{status: ST_OK, start_page: sel_start};
          state_d      = S_DONE;
        end else if (last) begin
          res_d   = '{status: ST_NOFIT, start_page: '0};
          state_d = S_DONE;
        end else begin
          addr_d  = addr_q + AW'(1);
          rd_en   = 1'b1;
          rd_addr = addr_q + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      high_used_q <= '0;
      low_used_q  <= '0;
    end else begin
      state_q     <= state_d;
      high_used_q <= high_used_d;
      low_used_q  <= low_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pool_q  <= pool_d;
    count_q <= count_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign high_used_o = high_used_q;
  assign low_used_o  = low_used_q;

endmodule

// ===== sv/pef_free_acc.sv =====
// Running free-page total and its saturating KB figure.
// Depends on pef_pkg.
module pef_free_acc #(
  parameter int unsigned TABLE_ENTRIES = pef_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pef_pkg::free_upd_t         upd_i,
  output logic [pef_pkg::KB_W-1:0]   free_kb_o
);
  import pef_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_ENTRIES) + PAGE_W + 1;

  logic [SW-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (upd_i.add) sum_d = sum_q + SW'(upd_i.amount);
    if (upd_i.sub) sum_d = sum_q - SW'(upd_i.amount);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign free_kb_o = (|sum_q[SW-1:PAGE_W]) ? KB_MAX
                                           : {sum_q[PAGE_W-1:0], {KB_SHIFT{1'b0}}};

endmodule

// ===== sv/page_extent_first_fit_allocator.sv =====
// Top level of the first-fit page extent allocator.
// Depends on pef_pkg, pef_if, pef_engine, pef_free_acc and the assertion header.
//
//   channel | dir | payload                          | transfer when
//   req_i   | in  | func, page_count, page_number    | valid & ready
//   rsp_o   | out | status, start_page, free_kb      | valid & ready
//
// An add appends one extent to its table; an allocation examines the extents in order
// (at most TABLE_ENTRIES), one read of the extent memory per cycle, until the first fit.
// Reset clears the fill counts and the free total; the tables need no clearing.
// A waiting response sits in the output register while the next request runs;
// ready falls from acceptance until the result is handed to that register.
`include "page_extent_first_fit_allocator_assert.svh"

module page_extent_first_fit_allocator #(
  parameter int unsigned TABLE_ENTRIES = pef_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pef_in_if.sink      req_i,
  pef_out_if.source   rsp_o
);
  import pef_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic                eng_ready, eng_valid, res_ready;
  result_t             eng_res;
  free_upd_t           upd;
  logic [CW-1:0]       high_used, low_used;
  logic [KB_W-1:0]     free_kb;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PAGE_W-1:0]   out_start_q;
  logic [KB_W-1:0]     out_kb_q;

  assign res_ready = !out_valid_q || rsp_o.ready;

  pef_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_i.valid && eng_ready),
    .func_i      (func_e'(req_i.func)),
    .count_i     (req_i.page_count),
    .page_i      (req_i.page_number),
    .ready_o     (eng_ready),
    .res_valid_o (eng_valid),
    .res_ready_i (res_ready),
    .res_o       (eng_res),
    .upd_o       (upd),
    .high_used_o (high_used),
    .low_used_o  (low_used)
  );

  pef_free_acc #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_free_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .free_kb_o (free_kb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= eng_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && eng_valid) begin
      out_status_q <= eng_res.status;
      out_start_q  <= eng_res.start_page;
      out_kb_q     <= free_kb;
    end
  end

  assign req_i.ready      = eng_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.start_page = out_start_q;
  assign rsp_o.free_kb    = out_kb_q;

  `PEF_ASSERT(a_ready_drops, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> !req_i.ready)
  `PEF_ASSERT_IMPLIES(a_fail_zero_start, clk_i, rst_ni, rsp_o.valid && (rsp_o.status != ST_OK), rsp_o.start_page == '0)
  `PEF_ASSERT_IMPLIES(a_used_bound, clk_i, rst_ni, 1'b1, (high_used <= CW'(TABLE_ENTRIES)) && (low_used <= CW'(TABLE_ENTRIES)))

endmodule

// ===== tb/sv/pef_free_extent_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the page extent allocator: mirrors both free-extent tables,
// predicts the response to every request transfer and compares each response transfer.
// Depends on pef_pkg and the pef_in_if / pef_out_if channel interfaces.
module pef_free_extent_checker #(
  parameter int unsigned ENTRIES = pef_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pef_in_if           req_i,
  pef_out_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  import pef_pkg::*;

  typedef struct packed {
    func_e             func;
    status_e           status;
    logic [PAGE_W-1:0] start_page;
    logic [KB_W-1:0]   free_kb;
  } grant_t;

  logic [PAGE_W-1:0]  hi_first [ENTRIES];
  logic [PAGE_W-1:0]  hi_len   [ENTRIES];
  logic [LPAGE_W-1:0] lo_first [ENTRIES];
  logic [LPAGE_W-1:0] lo_len   [ENTRIES];
  int unsigned        hi_fill;
  int unsigned        lo_fill;
  int unsigned        failures;
  grant_t             pending_grants [$];

  function automatic grant_t first_fit_outcome(input func_e fn,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [PAGE_W-1:0] pg);
    grant_t          g;
    longint unsigned pages;
    longint unsigned kb;
    bit              hit;
    g.func       = fn;
    g.status     = ST_OK;
    g.start_page = '0;
    hit          = 1'b0;
    pages        = 0;
    case (fn)
      FN_ALLOC_HIGH: begin
        for (int i = 0; i < hi_fill && !hit; i++) begin
          if (hi_len[i] >= cnt) begin
            g.start_page = hi_first[i];
            hi_first[i]  = hi_first[i] + cnt[PAGE_W-1:0];
            hi_len[i]    = hi_len[i] - cnt[PAGE_W-1:0];
            hit          = 1'b1;
          end
        end
        if (!hit) g.status = ST_NOFIT;
      end
      FN_ALLOC_LOW: begin
        for (int i = 0; i < lo_fill && !hit; i++) begin
          if (lo_len[i] >= cnt) begin
            g.start_page = PAGE_W'(lo_first[i]);
            lo_first[i]  = lo_first[i] + cnt[LPAGE_W-1:0];
            lo_len[i]    = lo_len[i] - cnt[LPAGE_W-1:0];
            hit          = 1'b1;
          end
        end
        if (!hit) g.status = ST_NOFIT;
      end
      FN_ADD_HIGH: begin
        if (hi_fill >= ENTRIES) begin
          g.status = ST_FULL;
        end else begin
          hi_first[hi_fill] = pg;
          hi_len[hi_fill]   = (cnt > HIGH_SIZE_MAX) ? HIGH_SIZE_MAX : cnt[PAGE_W-1:0];
          hi_fill++;
        end
      end
      default: begin
        if (lo_fill >= ENTRIES) begin
          g.status = ST_FULL;
        end else begin
          lo_first[lo_fill] = pg[LPAGE_W-1:0];
          lo_len[lo_fill]   = (cnt > LOW_SIZE_MAX) ? LOW_SIZE_MAX : cnt[LPAGE_W-1:0];
          lo_fill++;
        end
      end
    endcase
    for (int i = 0; i < hi_fill; i++) pages += hi_len[i];
    for (int i = 0; i < lo_fill; i++) pages += lo_len[i];
    kb = pages * 4;
    g.free_kb = (kb > KB_MAX) ? KB_MAX : KB_W'(kb);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      hi_fill = 0;
      lo_fill = 0;
      failures = 0;
      pending_grants.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_grants.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected response: status %0d start %05h kb %0d",
                     rsp_i.status, rsp_i.start_page, rsp_i.free_kb);
        end else begin
          want = pending_grants.pop_front();
          if (rsp_i.status !== want.status || rsp_i.start_page !== want.start_page ||
              rsp_i.free_kb !== want.free_kb) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch on %s: expected status %0d start %05h kb %0d",
                       want.func.name(), want.status, want.start_page, want.free_kb);
              $display("  got status %0d start %05h kb %0d",
                       rsp_i.status, rsp_i.start_page, rsp_i.free_kb);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready)
        pending_grants.push_back(first_fit_outcome(func_e'(req_i.func), req_i.page_count,
                                                   req_i.page_number));
      fail_count_o  <= failures;
      outstanding_o <= pending_grants.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the page extent allocator testbench: clock, reset, request stimulus and verdict.
// Depends on pef_pkg, pef_if, page_extent_first_fit_allocator and pef_free_extent_checker.
module tb;
  import pef_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES_DEF + 8;
  localparam int unsigned PHASE_ITEMS  = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles = 0;

  pef_in_if  req ();
  pef_out_if rsp ();

  page_extent_first_fit_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  pef_free_extent_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rsp_i         (rsp),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_op(input func_e fn, input logic [COUNT_W-1:0] cnt,
                         input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.func        <= fn;
    req.page_count  <= cnt;
    req.page_number <= pg;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // hold off until every response has been returned
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic send_random();
    func_e              fn;
    logic [COUNT_W-1:0] cnt;
    logic [PAGE_W-1:0]  pg;
    int unsigned        pick;
    fn   = func_e'($urandom_range(3, 0));
    pg   = PAGE_W'($urandom);
    pick = $urandom_range(15, 0);
    case (fn)
      FN_ALLOC_HIGH: cnt = (pick < 3)  ? COUNT_W'($urandom) :
                           (pick < 10) ? COUNT_W'($urandom_range(255, 0)) :
                                         COUNT_W'($urandom_range(4095, 0));
      FN_ALLOC_LOW:  cnt = (pick == 0) ? COUNT_W'($urandom) :
                           (pick < 4)  ? COUNT_W'($urandom_range(300, 0)) :
                                         COUNT_W'($urandom_range(40, 0));
      FN_ADD_HIGH:   cnt = (pick == 0) ? COUNT_W'($urandom) :
                                         COUNT_W'($urandom_range(4095, 0));
      default:       cnt = (pick == 0) ? COUNT_W'($urandom) :
                                         COUNT_W'($urandom_range(300, 0));
    endcase
    send_op(fn, cnt, pg);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    req.valid       <= 1'b0;
    req.func        <= FN_ALLOC_HIGH;
    req.page_count  <= '0;
    req.page_number <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(FN_ALLOC_HIGH, 21'd0,        20'h00000);
    send_op(FN_ALLOC_LOW,  21'd5,        20'h00000);
    send_op(FN_ADD_HIGH,   21'h1FFFFF,   20'hFFFFF);
    send_op(FN_ADD_LOW,    21'h1FFFFF,   20'hFFFFF);
    send_op(FN_ALLOC_HIGH, 21'd0,        20'h00000);
    send_op(FN_ALLOC_HIGH, 21'd1,        20'h00000);
    send_op(FN_ALLOC_LOW,  21'd1,        20'h00000);
    send_op(FN_ALLOC_LOW,  21'd254,      20'h00000);
    send_op(FN_ALLOC_LOW,  21'd1,        20'h00000);
    send_op(FN_ALLOC_LOW,  21'd0,        20'h00000);
    send_op(FN_ALLOC_HIGH, 21'h100000,   20'h00000);
    send_op(FN_ALLOC_HIGH, 21'h0FFFFE,   20'h00000);
    send_op(FN_ADD_HIGH,   21'd0,        20'h00000);
    send_op(FN_ADD_HIGH,   21'd100,      20'h12345);
    send_op(FN_ALLOC_HIGH, 21'd100,      20'h00000);
    send_op(FN_ADD_HIGH,   21'h0FFFFF,   20'hABCDE);
    send_op(FN_ADD_HIGH,   21'h100000,   20'h54321);
    send_op(FN_ALLOC_HIGH, 21'h0FFFFF,   20'h00000);
    send_op(FN_ADD_LOW,    21'd0,        20'h00055);
    send_op(FN_ADD_LOW,    21'd255,      20'h000AB);
    send_op(FN_ADD_LOW,    21'd256,      20'hFFF00);
    send_op(FN_ALLOC_LOW,  21'd255,      20'h00000);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
      settle();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/pef_pkg.sv
sv/pef_if.sv
sv/pef_engine.sv
sv/pef_free_acc.sv
sv/page_extent_first_fit_allocator.sv
tb/sv/pef_free_extent_checker.sv
tb/sv/tb.sv
